FILE: rtl/core/tdp_pkg.sv
// ----------------------------------------------------------------------------
// tdp_pkg
// Shared types, constants and the control store for the trial division
// primality tester.
// ----------------------------------------------------------------------------
package tdp_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int UPC_WIDTH      = 4;

    typedef logic [UPC_WIDTH-1:0] upc_t;

    // datapath action of one step
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_DIV_INIT,
        ACT_DIV_STEP,
        ACT_ADVANCE,
        ACT_RES0,
        ACT_RES1,
        ACT_EMIT
    } act_t;

    // jump condition of one step
    typedef enum logic [3:0] {
        COND_ALWAYS,
        COND_IN_BEAT,
        COND_LT2,
        COND_LT4,
        COND_EVEN,
        COND_SQ_GT,
        COND_CNT_LAST,
        COND_REM_ZERO,
        COND_OUT_FREE
    } cond_t;

    // what happens when the condition is false
    typedef enum logic {
        FALL_NEXT,
        FALL_HOLD
    } fall_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        upc_t  target;
        fall_t fall;
    } uword_t;

    // flags from the datapath to the sequencer
    typedef struct packed {
        logic lt2;
        logic lt4;
        logic even;
        logic sq_gt;
        logic cnt_last;
        logic rem_zero;
    } dp_status_t;

    localparam upc_t STEP_WAIT      = upc_t'(0);
    localparam upc_t STEP_LT2       = upc_t'(1);
    localparam upc_t STEP_LT4       = upc_t'(2);
    localparam upc_t STEP_EVEN      = upc_t'(3);
    localparam upc_t STEP_BOUND     = upc_t'(4);
    localparam upc_t STEP_DIV       = upc_t'(5);
    localparam upc_t STEP_REM_TEST  = upc_t'(6);
    localparam upc_t STEP_ADVANCE   = upc_t'(7);
    localparam upc_t STEP_NOT_PRIME = upc_t'(8);
    localparam upc_t STEP_PRIME     = upc_t'(9);
    localparam upc_t STEP_EMIT      = upc_t'(10);

    function automatic uword_t tdp_rom(input upc_t pc);
        uword_t w;
        begin
            w = '{act: ACT_NONE, cond: COND_ALWAYS, target: STEP_WAIT, fall: FALL_NEXT};
            unique case (pc)
                STEP_WAIT:
                    w = '{act: ACT_LOAD, cond: COND_IN_BEAT, target: STEP_LT2,
                          fall: FALL_HOLD};
                STEP_LT2:
                    w = '{act: ACT_NONE, cond: COND_LT2, target: STEP_NOT_PRIME,
                          fall: FALL_NEXT};
                STEP_LT4:
                    w = '{act: ACT_NONE, cond: COND_LT4, target: STEP_PRIME,
                          fall: FALL_NEXT};
                STEP_EVEN:
                    w = '{act: ACT_NONE, cond: COND_EVEN, target: STEP_NOT_PRIME,
                          fall: FALL_NEXT};
                STEP_BOUND:
                    w = '{act: ACT_DIV_INIT, cond: COND_SQ_GT, target: STEP_PRIME,
                          fall: FALL_NEXT};
                STEP_DIV:
                    w = '{act: ACT_DIV_STEP, cond: COND_CNT_LAST, target: STEP_REM_TEST,
                          fall: FALL_HOLD};
                STEP_REM_TEST:
                    w = '{act: ACT_NONE, cond: COND_REM_ZERO, target: STEP_NOT_PRIME,
                          fall: FALL_NEXT};
                STEP_ADVANCE:
                    w = '{act: ACT_ADVANCE, cond: COND_ALWAYS, target: STEP_BOUND,
                          fall: FALL_NEXT};
                STEP_NOT_PRIME:
                    w = '{act: ACT_RES0, cond: COND_ALWAYS, target: STEP_EMIT,
                          fall: FALL_NEXT};
                STEP_PRIME:
                    w = '{act: ACT_RES1, cond: COND_ALWAYS, target: STEP_EMIT,
                          fall: FALL_NEXT};
                STEP_EMIT:
                    w = '{act: ACT_EMIT, cond: COND_OUT_FREE, target: STEP_WAIT,
                          fall: FALL_HOLD};
                default:
                    w = '{act: ACT_NONE, cond: COND_ALWAYS, target: STEP_WAIT,
                          fall: FALL_NEXT};
            endcase
            return w;
        end
    endfunction

endpackage

FILE: rtl/core/trial_division_primality.sv
// ----------------------------------------------------------------------------
// trial_division_primality
// Reports whether a signed number is prime by trial division, run by a
// small microprogram over a bit-serial remainder datapath.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+-----------------------
//   in      | in_valid  | in_stall  | number (signed)
//   out     | out_valid | out_stall | is_prime
//
// values below 2 are rejected first, then two and three are accepted and
// even values rejected; each odd divisor tried takes a bound test on its
// square, a bit-serial division over all DATA_WIDTH bits of the number, a
// remainder test and, if it does not divide, a step to the next divisor.
// rst_n clears the step counter and the output beat.
// a new number is taken only in the wait step; a waiting result does not
// block the next beat in, and the program holds in its emit step while the
// output register is still full and stalled.
// ----------------------------------------------------------------------------
module trial_division_primality
    import tdp_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [DATA_WIDTH-1:0] number,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         is_prime
);

    upc_t       pc_reg, pc_next;
    logic       res_reg, res_next;
    logic       out_valid_reg, out_valid_next;
    logic       is_prime_reg, is_prime_next;
    uword_t     ctrl;
    dp_status_t status;
    logic       in_beat;
    logic       out_free;
    logic       cond_true;

    assign ctrl     = tdp_rom(pc_reg);
    assign in_stall = (ctrl.act != ACT_LOAD);
    assign in_beat  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    tdp_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk    (clk),
        .load   (in_beat),
        .act    (ctrl.act),
        .number (number),
        .status (status)
    );

    always_comb
    begin
        unique case (ctrl.cond)
            COND_ALWAYS:   cond_true = 1'b1;
            COND_IN_BEAT:  cond_true = in_beat;
            COND_LT2:      cond_true = status.lt2;
            COND_LT4:      cond_true = status.lt4;
            COND_EVEN:     cond_true = status.even;
            COND_SQ_GT:    cond_true = status.sq_gt;
            COND_CNT_LAST: cond_true = status.cnt_last;
            COND_REM_ZERO: cond_true = status.rem_zero;
            COND_OUT_FREE: cond_true = out_free;
            default:       cond_true = 1'b1;
        endcase
    end

    always_comb
    begin
        priority if (cond_true)
            pc_next = ctrl.target;
        else if (ctrl.fall == FALL_HOLD)
            pc_next = pc_reg;
        else
            pc_next = pc_reg + upc_t'(1);
    end

    always_comb
    begin
        res_next = res_reg;
        if (ctrl.act == ACT_RES0)
            res_next = 1'b0;
        else if (ctrl.act == ACT_RES1)
            res_next = 1'b1;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        is_prime_next  = is_prime_reg;
        priority if (ctrl.act == ACT_EMIT && out_free)
        begin
            out_valid_next = 1'b1;
            is_prime_next  = res_reg;
        end
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= STEP_WAIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg      <= res_next;
        is_prime_reg <= is_prime_next;
    end

    assign out_valid = out_valid_reg;
    assign is_prime  = is_prime_reg;

endmodule

FILE: rtl/core/tdp_datapath.sv
// ----------------------------------------------------------------------------
// tdp_datapath
// Operand, divisor, square and bit-serial remainder registers driven by the
// control word of the sequencer.
// ----------------------------------------------------------------------------
module tdp_datapath
    import tdp_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  load,
    input  act_t                  act,
    input  logic [DATA_WIDTH-1:0] number,
    output dp_status_t            status
);

    localparam int DW = DATA_WIDTH / 2 + 2;
    localparam int SW = DATA_WIDTH + 2;
    localparam int CW = $clog2(DATA_WIDTH);

    logic [DATA_WIDTH-1:0] n_reg,   n_next;
    logic [DW-1:0]         d_reg,   d_next;
    logic [SW-1:0]         sq_reg,  sq_next;
    logic [DW-1:0]         rem_reg, rem_next;
    logic [DATA_WIDTH-1:0] q_reg,   q_next;
    logic [CW-1:0]         cnt_reg, cnt_next;

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          fits;
    logic [DW-1:0] rem_step;
    logic [SW-1:0] sq_step;

    always_comb
    begin
        trial    = {rem_reg, q_reg[DATA_WIDTH-1]};
        fits     = trial >= {1'b0, d_reg};
        diff     = trial - {1'b0, d_reg};
        rem_step = fits ? diff[DW-1:0] : trial[DW-1:0];
        // (d+2)^2 = d^2 + 4d + 4
        sq_step  = sq_reg + SW'({d_reg, 2'b00}) + SW'(4);
    end

    always_comb
    begin
        n_next   = n_reg;
        d_next   = d_reg;
        sq_next  = sq_reg;
        rem_next = rem_reg;
        q_next   = q_reg;
        cnt_next = cnt_reg;
        unique case (act)
            ACT_LOAD:
            begin
                if (load)
                begin
                    n_next  = number;
                    d_next  = DW'(3);
                    sq_next = SW'(9);
                end
            end
            ACT_DIV_INIT:
            begin
                rem_next = '0;
                q_next   = n_reg;
                cnt_next = CW'(DATA_WIDTH - 1);
            end
            ACT_DIV_STEP:
            begin
                rem_next = rem_step;
                q_next   = {q_reg[DATA_WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg - CW'(1);
            end
            ACT_ADVANCE:
            begin
                d_next  = d_reg + DW'(2);
                sq_next = sq_step;
            end
            ACT_NONE, ACT_RES0, ACT_RES1, ACT_EMIT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        d_reg   <= d_next;
        sq_reg  <= sq_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
    end

    always_comb
    begin
        status.lt2      = n_reg[DATA_WIDTH-1] || (n_reg[DATA_WIDTH-1:1] == '0);
        status.lt4      = (n_reg[DATA_WIDTH-1:2] == '0);
        status.even     = !n_reg[0];
        status.sq_gt    = sq_reg > SW'(n_reg);
        status.cnt_last = (cnt_reg == '0);
        status.rem_zero = (rem_reg == '0);
    end

endmodule
